// ===== rtl/drd_pkg.sv =====
// Shared widths, limits, register indexes, mode values and the lane control type for the dehaze restore block.
`timescale 1ns / 1ps
`default_nettype none
package drd_pkg;
    localparam int PIX_W      = 8;
    localparam int TRANS_W    = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int STEP_LIMIT = 20;
    localparam int FLAT_LIMIT = 30;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_B     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_G     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_R     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRANS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_EN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DB_LIMIT  = 3'd5;

    // input kind carried on tuser
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_GAMMA = 1'b1;

    // deblock lane control
    typedef struct packed {
        logic load;
        logic step;
    } t_db_ctl;
endpackage
`default_nettype wire

// ===== rtl/drd_restore_lane.sv =====
// One channel lane: floor((I-A)*2^F / t) + A by a bit-serial divider, clamped to a byte.
`timescale 1ns / 1ps
`default_nettype none
module drd_restore_lane #(
    parameter int TRANS_FRAC_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [drd_pkg::PIX_W-1:0]     i_pix,
    input  wire logic [drd_pkg::PIX_W-1:0]     i_air,
    input  wire logic [drd_pkg::TRANS_W-1:0]   i_den,
    output logic                               o_done,
    output logic [drd_pkg::PIX_W-1:0]          o_val
);
    localparam int NUM_W = drd_pkg::PIX_W + TRANS_FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam int RW    = drd_pkg::TRANS_W;

    logic [NUM_W-1:0]          r_mag;
    logic [RW-1:0]             r_rem;
    logic [RW-1:0]             r_den;
    logic [drd_pkg::PIX_W-1:0] r_air;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_fin;
    logic                      r_done;
    logic [drd_pkg::PIX_W-1:0] r_val;

    logic [RW:0]               trial;
    logic                      qbit;
    logic [RW:0]               diff;
    logic signed [NUM_W+1:0]   qs;
    logic signed [NUM_W+1:0]   sum;
    logic [drd_pkg::PIX_W-1:0] n_val;

    // one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_mag[NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // floor for negative numerator, add airlight back, clamp
    always_comb begin
        qs = $signed({2'b00, r_mag});
        if (r_neg) begin
            qs = -(qs + $signed({{(NUM_W+1){1'b0}}, (r_rem != '0)}));
        end
        sum = qs + $signed({{(NUM_W+2-drd_pkg::PIX_W){1'b0}}, r_air});
        if (sum < 0) begin
            n_val = '0;
        end else if (sum > 255) begin
            n_val = '1;
        end else begin
            n_val = sum[drd_pkg::PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= (i_pix < i_air);
            r_mag <= {((i_pix < i_air) ? (i_air - i_pix) : (i_pix - i_air)),
                      {TRANS_FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= (i_den == '0) ? RW'(1) : i_den;
            r_air <= i_air;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[RW-1:0] : trial[RW-1:0];
            r_mag <= {r_mag[NUM_W-2:0], qbit};
        end
        if (r_fin) begin
            r_val <= n_val;
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;
endmodule
`default_nettype wire

// ===== rtl/drd_deblock_lane.sv =====
// One channel lane of the deblocker: step and flatness terms, ramp correction per position.
`timescale 1ns / 1ps
`default_nettype none
module drd_deblock_lane #(
    parameter int DEBLOCK_STEPS = 10
) (
    input  wire logic                       i_clk,
    input  wire drd_pkg::t_db_ctl           i_ctl,
    input  wire logic [drd_pkg::PIX_W-1:0]  i_cur,
    input  wire logic [drd_pkg::PIX_W-1:0]  i_prev,
    input  wire logic [drd_pkg::PIX_W-1:0]  i_far,
    input  wire logic [drd_pkg::PIX_W-1:0]  i_near,
    input  wire logic [drd_pkg::PIX_W-1:0]  i_pix,
    output logic [drd_pkg::PIX_W-1:0]       o_absd,
    output logic [drd_pkg::PIX_W:0]         o_flat,
    output logic [drd_pkg::PIX_W-1:0]       o_pix
);
    localparam int PW    = drd_pkg::PIX_W;
    localparam int ACC_W = PW + 1 + $clog2(DEBLOCK_STEPS + 1);
    localparam int K     = ACC_W + 6;
    localparam int RECIP = (1 << K) / DEBLOCK_STEPS + 1;

    logic signed [PW:0]      r_d;
    logic signed [ACC_W-1:0] r_acc;

    logic signed [PW:0]      d_now;
    logic [PW-1:0]           a_far;
    logic [PW-1:0]           a_near;
    logic                    neg;
    logic [ACC_W:0]          mag;
    logic [ACC_W+K:0]        prod;
    logic [ACC_W:0]          q;
    logic signed [ACC_W+2:0] qs;
    logic signed [ACC_W+2:0] sum;

    // step and flatness of this channel
    always_comb begin
        d_now  = $signed({1'b0, i_cur}) - $signed({1'b0, i_prev});
        o_absd = d_now[PW] ? PW'(-d_now) : d_now[PW-1:0];
        a_far  = (i_prev > i_far) ? (i_prev - i_far) : (i_far - i_prev);
        a_near = (i_cur > i_near) ? (i_cur - i_near) : (i_near - i_cur);
        o_flat = {1'b0, a_far} + {1'b0, a_near};
    end

    // floor(s*d/STEPS) by reciprocal multiply on the magnitude
    always_comb begin
        neg  = r_acc[ACC_W-1];
        mag  = neg ? ((ACC_W+1)'(-r_acc) + (ACC_W+1)'(DEBLOCK_STEPS - 1))
                   : (ACC_W+1)'(r_acc);
        prod = {{K{1'b0}}, mag} * (ACC_W+K+1)'(RECIP);
        q    = prod[K +: ACC_W+1];
        qs   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum  = qs + $signed({{(ACC_W+3-PW){1'b0}}, i_pix});
        if (sum < 0) begin
            o_pix = '0;
        end else if (sum > 255) begin
            o_pix = '1;
        end else begin
            o_pix = sum[PW-1:0];
        end
    end

    // acc holds s*d for the current step
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_d   <= d_now;
            r_acc <= ACC_W'(d_now);
        end else if (i_ctl.step) begin
            r_acc <= r_acc + ACC_W'(r_d);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/dehaze_restore_deblock.sv =====
// One pixel in flight: the input is ready only in idle, so a new pixel waits until the last one
// has passed the divider lanes, the gamma reads and the window step (bypass or through the window),
// any deblock ramp when the deblocker fires, and its output handshake when it emits.
// Row end flush: alignment shifts bring the held pixels to the last tap, then they leave oldest first.
// Reset (sync, active low): registers to defaults, count and flags cleared; gamma, window undefined.
`timescale 1ns / 1ps
`default_nettype none
module dehaze_restore_deblock #(
    parameter int TRANS_FRAC_BITS = 12,
    parameter int DEBLOCK_STEPS   = 10,
    parameter int DEBLOCK_OFFSET  = 20
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // config write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [drd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [drd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // blue_in[7:0], green_in[15:8], red_in[23:16], transmission[35:24],
    // table_index[43:36], table_value[51:44], zero pad [55:52]
    input  wire logic [55:0]                      i_s_axis_tdata,
    input  wire logic                             i_s_axis_tlast,   // last_in_row
    input  wire logic                             i_s_axis_tuser,   // mode
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // blue_out[7:0], green_out[15:8], red_out[23:16]
    output logic [23:0]                           o_m_axis_tdata,
    output logic                                  o_m_axis_tlast    // row_end
);
    localparam int PW     = drd_pkg::PIX_W;
    localparam int TW     = drd_pkg::TRANS_W;
    localparam int WIN    = DEBLOCK_OFFSET + DEBLOCK_STEPS + 2;
    localparam int FLAGS  = DEBLOCK_OFFSET + 1;
    localparam int NEARP  = (DEBLOCK_OFFSET + 1 >= DEBLOCK_STEPS)
                            ? DEBLOCK_OFFSET + 1 - DEBLOCK_STEPS : 0;
    localparam int WIN_IW = $clog2(WIN);
    localparam int CNT_W  = $clog2(WIN + 1);
    localparam int S_W    = $clog2(DEBLOCK_STEPS + 1);
    localparam logic [WIN_IW-1:0] LAST_TAP = WIN_IW'(WIN - 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DIV   = 4'd1;
    localparam logic [3:0] ST_GB    = 4'd2;
    localparam logic [3:0] ST_GG    = 4'd3;
    localparam logic [3:0] ST_GR    = 4'd4;
    localparam logic [3:0] ST_GD    = 4'd5;
    localparam logic [3:0] ST_DEC   = 4'd6;
    localparam logic [3:0] ST_CHK   = 4'd7;
    localparam logic [3:0] ST_DB    = 4'd8;
    localparam logic [3:0] ST_POST  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_FLUSH = 4'd11;
    localparam logic [3:0] ST_FOUT  = 4'd12;

    // config registers
    logic [PW-1:0] r_air [3];
    logic [TW-1:0] r_min_t;
    logic          r_post_en;
    logic [TW-1:0] r_db_limit;

    // control
    logic [3:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_skip;
    logic [CNT_W-1:0] r_rem;
    logic [S_W-1:0]   r_s;
    logic [FLAGS-1:0] r_flags;
    logic             r_out_valid;

    // payload
    logic [PW-1:0]    r_in_pix [3];
    logic [TW-1:0]    r_t;
    logic [TW-1:0]    r_te;
    logic             r_last;
    logic [PW-1:0]    r_px [3];
    logic [23:0]      r_out_data;
    logic             r_out_last;
    logic [23:0]      r_win [WIN];
    logic [PW-1:0]    r_gmem [256];
    logic [PW-1:0]    r_g_rd;

    logic             in_beat;
    logic             out_beat;
    logic             start_div;
    logic [TW-1:0]    in_t;
    logic [TW-1:0]    n_te;
    logic [PW-1:0]    g_addr;
    logic [PW-1:0]    div_val [3];
    logic             div_done [3];
    drd_pkg::t_db_ctl db_ctl;
    logic [PW-1:0]    lane_absd [3];
    logic [PW:0]      lane_flat [3];
    logic [PW-1:0]    lane_pix [3];
    logic [WIN_IW-1:0] db_pos;
    logic [PW+2:0]    flat_sum;
    logic             db_ok;
    logic             db_fire;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_beat        = r_out_valid && i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air[0]   <= 8'd255;
            r_air[1]   <= 8'd255;
            r_air[2]   <= 8'd255;
            r_min_t    <= 12'd410;
            r_post_en  <= 1'b0;
            r_db_limit <= 12'd1638;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                drd_pkg::CFG_AIR_B:     r_air[0]   <= i_cfg_data[PW-1:0];
                drd_pkg::CFG_AIR_G:     r_air[1]   <= i_cfg_data[PW-1:0];
                drd_pkg::CFG_AIR_R:     r_air[2]   <= i_cfg_data[PW-1:0];
                drd_pkg::CFG_MIN_TRANS: r_min_t    <= i_cfg_data[TW-1:0];
                drd_pkg::CFG_POST_EN:   r_post_en  <= i_cfg_data[0];
                drd_pkg::CFG_DB_LIMIT:  r_db_limit <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // effective divisor; zero is replaced by one inside the lanes
    assign in_t = i_s_axis_tdata[35:24];
    assign n_te = (in_t > r_min_t) ? in_t : r_min_t;

    // latch the input beat
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in_pix[0] <= i_s_axis_tdata[7:0];
            r_in_pix[1] <= i_s_axis_tdata[15:8];
            r_in_pix[2] <= i_s_axis_tdata[23:16];
            r_t         <= in_t;
            r_te        <= n_te;
            r_last      <= i_s_axis_tlast;
        end
    end

    assign start_div = (r_state == ST_DIV) && (r_skip == CNT_W'(1));

    // restore lanes, one per channel
    for (genvar c = 0; c < 3; c++) begin : g_restore
        drd_restore_lane #(
            .TRANS_FRAC_BITS(TRANS_FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_start(start_div),
            .i_pix  (r_in_pix[c]),
            .i_air  (r_air[c]),
            .i_den  (r_te),
            .o_done (div_done[c]),
            .o_val  (div_val[c])
        );
    end

    // gamma table memory, one read a cycle
    always_comb begin
        unique case (r_state)
            ST_GG:   g_addr = div_val[1];
            ST_GR:   g_addr = div_val[2];
            default: g_addr = div_val[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && (i_s_axis_tuser == drd_pkg::MODE_GAMMA)) begin
            r_gmem[i_s_axis_tdata[43:36]] <= i_s_axis_tdata[51:44];
        end
        r_g_rd <= r_gmem[g_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_GG) begin
            r_px[0] <= r_g_rd;
        end
        if (r_state == ST_GR) begin
            r_px[1] <= r_g_rd;
        end
        if (r_state == ST_GD) begin
            r_px[2] <= r_g_rd;
        end
    end

    // deblock lanes, one per channel
    assign db_pos = LAST_TAP - WIN_IW'(r_s);

    for (genvar c = 0; c < 3; c++) begin : g_deblock
        drd_deblock_lane #(
            .DEBLOCK_STEPS(DEBLOCK_STEPS)
        ) u_lane (
            .i_clk (i_clk),
            .i_ctl (db_ctl),
            .i_cur (r_win[DEBLOCK_OFFSET][8*c +: 8]),
            .i_prev(r_win[DEBLOCK_OFFSET+1][8*c +: 8]),
            .i_far (r_win[WIN-1][8*c +: 8]),
            .i_near(r_win[NEARP][8*c +: 8]),
            .i_pix (r_win[db_pos][8*c +: 8]),
            .o_absd(lane_absd[c]),
            .o_flat(lane_flat[c]),
            .o_pix (lane_pix[c])
        );
    end

    // merge what the lanes found
    always_comb begin
        flat_sum = (PW+3)'(lane_flat[0]) + (PW+3)'(lane_flat[1]) + (PW+3)'(lane_flat[2]);
        db_ok    = (lane_absd[0] < PW'(drd_pkg::STEP_LIMIT))
                && (lane_absd[1] < PW'(drd_pkg::STEP_LIMIT))
                && (lane_absd[2] < PW'(drd_pkg::STEP_LIMIT))
                && (flat_sum < (PW+3)'(drd_pkg::FLAT_LIMIT));
        db_fire  = r_post_en && (r_cnt == CNT_W'(WIN)) && r_flags[DEBLOCK_OFFSET] && db_ok;
        db_ctl.load = (r_state == ST_CHK) && db_fire;
        db_ctl.step = (r_state == ST_DB) && (r_s != S_W'(DEBLOCK_STEPS));
    end

    // pixel window
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DEC) && (r_post_en || (r_cnt != '0))) begin
            for (int i = WIN - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
            r_win[0] <= {r_px[2], r_px[1], r_px[0]};
        end else if (r_state == ST_DB) begin
            r_win[db_pos] <= {lane_pix[2], lane_pix[1], lane_pix[0]};
        end else if (r_state == ST_FLUSH) begin
            for (int i = WIN - 1; i > 0; i--) begin
                r_win[i] <= r_win[i-1];
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DEC) && !r_post_en && (r_cnt == '0)) begin
            r_out_data <= {r_px[2], r_px[1], r_px[0]};
            r_out_last <= r_last;
        end else if ((r_state == ST_POST) && !r_last) begin
            r_out_data <= r_win[WIN-1];
            r_out_last <= 1'b0;
        end else if ((r_state == ST_FLUSH) && (r_skip == '0)) begin
            r_out_data <= r_win[WIN-1];
            r_out_last <= (r_rem == CNT_W'(1));
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_skip      <= '0;
            r_rem       <= '0;
            r_s         <= '0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat && (i_s_axis_tuser == drd_pkg::MODE_PIXEL)) begin
                        r_state <= ST_DIV;
                        r_skip  <= CNT_W'(1);
                    end
                end
                ST_DIV: begin
                    // r_skip flags the start cycle of the lanes
                    r_skip <= '0;
                    if (div_done[0]) begin
                        r_state <= ST_GB;
                    end
                end
                ST_GB: r_state <= ST_GG;
                ST_GG: r_state <= ST_GR;
                ST_GR: r_state <= ST_GD;
                ST_GD: r_state <= ST_DEC;
                ST_DEC: begin
                    if (!r_post_en && (r_cnt == '0)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end else begin
                        r_flags <= {r_flags[FLAGS-2:0], (r_t < r_db_limit)};
                        if (r_cnt != CNT_W'(WIN)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= ST_CHK;
                    end
                end
                ST_CHK: begin
                    if (db_fire) begin
                        r_s     <= S_W'(1);
                        r_state <= ST_DB;
                    end else begin
                        r_state <= ST_POST;
                    end
                end
                ST_DB: begin
                    if (r_s == S_W'(DEBLOCK_STEPS)) begin
                        r_state <= ST_POST;
                    end else begin
                        r_s <= r_s + 1'b1;
                    end
                end
                ST_POST: begin
                    priority if (r_last) begin
                        r_skip  <= CNT_W'(WIN) - r_cnt;
                        r_rem   <= r_cnt;
                        r_cnt   <= '0;
                        r_flags <= '0;
                        r_state <= ST_FLUSH;
                    end else if (r_cnt == CNT_W'(WIN)) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_beat) begin
                        r_out_valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    if (r_skip != '0) begin
                        r_skip <= r_skip - 1'b1;
                    end else begin
                        r_rem       <= r_rem - 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_FOUT;
                    end
                end
                ST_FOUT: begin
                    if (out_beat) begin
                        r_out_valid <= 1'b0;
                        r_state     <= (r_rem == '0) ? ST_IDLE : ST_FLUSH;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
